// ===== design/html_text_entity_renderer_macros.svh =====
// ----------------------------------------------------------------------------
// HTML text entity renderer assertion macros
// Concurrent check helpers that compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef HTML_TEXT_ENTITY_RENDERER_MACROS_SVH
`define HTML_TEXT_ENTITY_RENDERER_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define HTER_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication that must hold in the same cycle.
`define HTER_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define HTER_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define HTER_ASSERT(name, cond, msg)
`define HTER_ASSERT_IMP(name, pre, post, msg)
`define HTER_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ===== design/hter_pkg.sv =====
// ----------------------------------------------------------------------------
// HTML text entity renderer package
// Shared types, character constants and escape/digit helper functions.
// ----------------------------------------------------------------------------
package hter_pkg;

    // Item kinds carried on the input tuser field.
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_ENTITY = 2'd1;
    localparam logic [1:0] KIND_NULL   = 2'd2;

    // Output burst limit per input word and its counter width.
    localparam int          N_W         = 6;
    localparam logic [5:0]  MAX_RESULTS = 6'd36;

    // Code point accumulator.
    localparam int          ACC_W    = 21;
    localparam logic [20:0] CP_LIMIT = 21'h10FFFF;
    localparam logic [20:0] CP_SAT   = 21'h110000;

    // Characters that steer decoding.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;

    // U+FFFD in UTF-8, first byte in the low bits.
    localparam logic [23:0] REPL_BYTES = 24'hBDBFEF;

    // Entity strings, first character in the top byte.
    localparam logic [47:0] STR_AMP  = {"&amp;", 8'h00};
    localparam logic [47:0] STR_LT   = {"&lt;", 16'h0000};
    localparam logic [47:0] STR_GT   = {"&gt;", 16'h0000};
    localparam logic [47:0] STR_QUOT = "&quot;";

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC,
        ST_RAW,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_HDR4,
        ST_BYTE_RD,
        ST_BYTE_USE,
        ST_DIG_RD,
        ST_DIG_USE,
        ST_CP
    } state_t;

    // Number of output bytes a byte expands to.
    function automatic logic [2:0] esc_len(input logic [7:0] b, input logic esc);
        logic [2:0] n;
        n = 3'd1;
        if (esc)
        begin
            case (b)
                CH_AMP:  n = 3'd5;
                CH_LT:   n = 3'd4;
                CH_GT:   n = 3'd4;
                CH_QUOT: n = 3'd6;
                default: n = 3'd1;
            endcase
        end
        return n;
    endfunction

    // Output byte number sub of the expansion of b.
    function automatic logic [7:0] esc_char(input logic [7:0] b, input logic esc,
                                            input logic [2:0] sub);
        logic [47:0] s;
        s = {b, 40'h0};
        if (esc)
        begin
            case (b)
                CH_AMP:  s = STR_AMP;
                CH_LT:   s = STR_LT;
                CH_GT:   s = STR_GT;
                CH_QUOT: s = STR_QUOT;
                default: s = {b, 40'h0};
            endcase
        end
        s = s << {sub, 3'b000};
        return s[47:40];
    endfunction

    // Digit value, wrapping like the byte arithmetic it replaces.
    function automatic logic [7:0] digit_val(input logic [7:0] c, input logic hex);
        logic [7:0] d;
        if (!hex || (c >= CH_ZERO && c <= CH_NINE))
            d = c - CH_ZERO;
        else if (c >= CH_UA && c <= CH_UZ)
            d = c - CH_UA + 8'd10;
        else
            d = c - CH_LA + 8'd10;
        return d;
    endfunction

endpackage

// ===== design/hter_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module hter_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/html_text_entity_renderer.sv =====
// ----------------------------------------------------------------------------
// HTML text entity renderer
// Escapes text bytes for HTML and decodes numeric character references.
// ----------------------------------------------------------------------------
// One input word is taken at a time; s_tready is high while the block is idle.
// A text byte gives 1 to 6 output bytes at one per cycle while the output is
// not stalled, a null character 3. A non-final entity byte is written to the
// run store as it is taken. On the final byte the run is rendered from the
// store through its single registered read port: each stored byte is read,
// then used, then its output bytes are sent. Outside verbatim mode a run of
// more than three bytes is first read at its second byte and checked for '#'
// there; a numeric reference then reads its third and last bytes, reads and
// adds in each digit, encodes the code point and sends its output bytes. A
// burst is cut at 36 output bytes. The output register lets the next input
// word be taken while the last result still waits.
`include "html_text_entity_renderer_macros.svh"

module html_text_entity_renderer
    import hter_pkg::*;
#(
    parameter int ENTITY_MAX_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration: verbatim mode for entity runs.
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic [1:0] s_tuser,   // [1:0] text_kind
    input  logic       s_tlast,   // last_in
    // Output stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last_out
);

    localparam int IDX_W = $clog2(ENTITY_MAX_BYTES);
    localparam int CNT_W = $clog2(ENTITY_MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(ENTITY_MAX_BYTES);

    state_t             state_reg, state_next;
    logic               verbatim_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [7:0]         byte_reg, byte_next;
    logic               esc_reg, esc_next;
    logic               run_reg, run_next;
    logic               hex_reg, hex_next;
    logic [2:0]         sub_reg, sub_next;
    logic [31:0]        enc_reg, enc_next;
    logic [2:0]         raw_cnt_reg, raw_cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [7:0]         m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    logic               s_fire;
    logic               out_free;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               str_end;
    logic               seq_end;
    logic               emit_last;
    logic               idx_last;
    logic [CNT_W-1:0]   len_new;
    logic [CNT_W-1:0]   dig_start;
    logic [CNT_W-1:0]   dig_end;
    logic [CNT_W-1:0]   idx_inc;
    logic [25:0]        acc_mul;
    logic [25:0]        acc_sum;
    logic [ACC_W-1:0]   acc_upd;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [7:0]         ram_rdata;

    // Run store.
    hter_ram #(
        .WIDTH (8),
        .DEPTH (ENTITY_MAX_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and emission qualifiers.
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = out_free && (state_reg == ST_ESC || state_reg == ST_RAW);
    assign idx_last  = (idx_reg == len_reg - CNT_W'(1));
    assign str_end   = (state_reg == ST_ESC) ? (sub_reg == esc_len(byte_reg, esc_reg) - 3'd1)
                                             : (raw_cnt_reg == 3'd1);
    assign seq_end   = str_end && !((state_reg == ST_ESC) && run_reg && !idx_last);
    assign emit_last = seq_end || (n_reg == MAX_RESULTS - 6'd1);
    assign emit_byte = (state_reg == ST_ESC) ? esc_char(byte_reg, esc_reg, sub_reg)
                                             : enc_reg[7:0];

    // Run length after storing the incoming byte.
    assign len_new   = (count_reg < MAX_CNT) ? count_reg + CNT_W'(1) : count_reg;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign dig_start = hex_reg ? CNT_W'(3) : CNT_W'(2);
    assign dig_end   = (ram_rdata == CH_SEMI) ? len_reg - CNT_W'(1) : len_reg;

    // Accumulator step: acc * base + digit, saturating above the code point range.
    assign acc_mul = hex_reg ? {1'b0, acc_reg, 4'b0000}
                             : ({2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0});
    assign acc_sum = acc_mul + {18'b0, digit_val(ram_rdata, hex_reg)};
    assign acc_upd = (acc_sum > {5'b00000, CP_LIMIT}) ? CP_SAT : acc_sum[ACC_W-1:0];

    // Store write on every accepted run byte that still fits.
    assign ram_we    = s_fire && (s_tuser == KIND_ENTITY) && (count_reg < MAX_CNT);
    assign ram_waddr = count_reg[IDX_W-1:0];

    // Store read address per state.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_HDR1:
            begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(1);
            end
            ST_HDR2:
            begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(2);
            end
            ST_HDR3:
            begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(len_reg - CNT_W'(1));
            end
            ST_BYTE_RD, ST_DIG_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg[IDX_W-1:0];
            end
            default:
            begin
                ram_re    = 1'b0;
                ram_raddr = idx_reg[IDX_W-1:0];
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_tuser)
                        KIND_TEXT:
                            state_next = ST_ESC;
                        KIND_NULL:
                            state_next = ST_RAW;
                        KIND_ENTITY:
                        begin
                            if (s_tlast)
                            begin
                                if (verbatim_reg || len_new <= CNT_W'(3))
                                    state_next = ST_BYTE_RD;
                                else
                                    state_next = ST_HDR1;
                            end
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ESC:
            begin
                if (emit)
                begin
                    if (n_reg == MAX_RESULTS - 6'd1 || seq_end)
                        state_next = ST_IDLE;
                    else if (str_end)
                        state_next = ST_BYTE_RD;
                end
            end
            ST_RAW:
            begin
                if (emit && emit_last)
                    state_next = ST_IDLE;
            end
            ST_HDR1:
                state_next = ST_HDR2;
            ST_HDR2:
                state_next = (ram_rdata == CH_HASH) ? ST_HDR3 : ST_BYTE_RD;
            ST_HDR3:
                state_next = ST_HDR4;
            ST_HDR4:
                state_next = (dig_start < dig_end) ? ST_DIG_RD : ST_CP;
            ST_BYTE_RD:
                state_next = ST_BYTE_USE;
            ST_BYTE_USE:
                state_next = ST_ESC;
            ST_DIG_RD:
                state_next = ST_DIG_USE;
            ST_DIG_USE:
                state_next = (idx_inc < end_reg) ? ST_DIG_RD : ST_CP;
            ST_CP:
            begin
                if (acc_reg != '0 && acc_reg <= 21'h00007F)
                    state_next = ST_ESC;
                else
                    state_next = ST_RAW;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        count_next    = count_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        byte_next     = byte_reg;
        esc_next      = esc_reg;
        run_next      = run_reg;
        hex_next      = hex_reg;
        sub_next      = sub_reg;
        enc_next      = enc_reg;
        raw_cnt_next  = raw_cnt_reg;
        acc_next      = acc_reg;
        n_next        = n_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        // A taken output word frees the register.
        if (m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    n_next   = '0;
                    sub_next = 3'd0;
                    case (s_tuser)
                        KIND_TEXT:
                        begin
                            byte_next = s_tdata;
                            esc_next  = 1'b1;
                            run_next  = 1'b0;
                        end
                        KIND_NULL:
                        begin
                            enc_next     = {8'h00, REPL_BYTES};
                            raw_cnt_next = 3'd3;
                        end
                        KIND_ENTITY:
                        begin
                            count_next = len_new;
                            if (s_tlast)
                            begin
                                count_next = '0;
                                len_next   = len_new;
                                idx_next   = '0;
                                run_next   = 1'b1;
                            end
                        end
                        default:
                            count_next = count_reg;
                    endcase
                end
            end
            ST_ESC, ST_RAW:
            begin
                if (emit)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = emit_byte;
                    m_tlast_next  = emit_last;
                    n_next        = n_reg + 6'd1;
                    if (state_reg == ST_RAW)
                    begin
                        enc_next     = {8'h00, enc_reg[31:8]};
                        raw_cnt_next = raw_cnt_reg - 3'd1;
                    end
                    else if (str_end)
                    begin
                        sub_next = 3'd0;
                        idx_next = idx_inc;
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            ST_HDR3:
                hex_next = (ram_rdata == CH_LX) || (ram_rdata == CH_UX);
            ST_HDR4:
            begin
                end_next = dig_end;
                idx_next = dig_start;
                acc_next = '0;
            end
            ST_BYTE_USE:
            begin
                byte_next = ram_rdata;
                esc_next  = !verbatim_reg;
                sub_next  = 3'd0;
            end
            ST_DIG_USE:
            begin
                acc_next = acc_upd;
                idx_next = idx_inc;
            end
            ST_CP:
            begin
                // UTF-8 encoding, first byte in the low bits.
                sub_next = 3'd0;
                if (acc_reg == '0 || acc_reg > CP_LIMIT)
                begin
                    enc_next     = {8'h00, REPL_BYTES};
                    raw_cnt_next = 3'd3;
                end
                else if (acc_reg <= 21'h00007F)
                begin
                    byte_next = acc_reg[7:0];
                    esc_next  = 1'b1;
                    run_next  = 1'b0;
                end
                else if (acc_reg <= 21'h0007FF)
                begin
                    enc_next     = {16'h0000, 2'b10, acc_reg[5:0], 3'b110, acc_reg[10:6]};
                    raw_cnt_next = 3'd2;
                end
                else if (acc_reg <= 21'h00FFFF)
                begin
                    enc_next     = {8'h00, 2'b10, acc_reg[5:0], 2'b10, acc_reg[11:6],
                                    4'b1110, acc_reg[15:12]};
                    raw_cnt_next = 3'd3;
                end
                else
                begin
                    enc_next     = {2'b10, acc_reg[5:0], 2'b10, acc_reg[11:6],
                                    2'b10, acc_reg[17:12], 5'b11110, acc_reg[20:18]};
                    raw_cnt_next = 3'd4;
                end
            end
            default:
                n_next = n_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            verbatim_reg <= 1'b0;
            count_reg    <= '0;
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
                verbatim_reg <= cfg_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        end_reg     <= end_next;
        idx_reg     <= idx_next;
        byte_reg    <= byte_next;
        esc_reg     <= esc_next;
        run_reg     <= run_next;
        hex_reg     <= hex_next;
        sub_reg     <= sub_next;
        enc_reg     <= enc_next;
        raw_cnt_reg <= raw_cnt_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks.
    `HTER_ASSERT(a_burst_limit, n_reg <= MAX_RESULTS, "output burst exceeded its limit")
    `HTER_ASSERT(a_count_range, count_reg <= MAX_CNT, "run byte count exceeded the store")
    `HTER_ASSERT_IMP(a_emit_free, emit && m_tvalid_reg, m_tready, "output word overwritten")
    `HTER_ASSERT_IMP(a_read_in_run, state_reg == ST_BYTE_RD || state_reg == ST_DIG_RD,
                     idx_reg < len_reg, "store read beyond the current run")
    `HTER_ASSERT_NEXT(a_text_escapes, s_fire && s_tuser == KIND_TEXT,
                      state_reg == ST_ESC && n_reg == '0, "text byte did not start escaping")

endmodule

// ===== tb/sv/html_text_entity_renderer_tb.sv =====
// ----------------------------------------------------------------------------
// HTML text entity renderer testbench
// Drives classified text bytes into the renderer and checks every output word
// against an in-bench model of the escaping and the numeric reference decode.
// A short table of directed words comes first, then three random phases with
// different flow control and both settings of the verbatim register.
// ----------------------------------------------------------------------------
module html_text_entity_renderer_tb;
    import hter_pkg::*;

    localparam int          CLK_PERIOD       = 10;
    localparam int          RUN_DEPTH        = 32;
    localparam int          DRAIN_CYCLES     = 150;
    localparam int          RANDOM_PER_PHASE = 125;
    localparam int          TIMEOUT_TIME     = 15_000_000;
    localparam int          MAX_REPORTS      = 10;
    localparam int          USE_MODEL        = -1;
    localparam logic [1:0]  KIND_UNUSED      = 2'd3;

    // One input word and one rendered output word.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } text_word_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } rendered_t;

    // One row of the directed table. A row with a typed result lists its
    // bytes first byte in the top bits; other rows are predicted.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        int          want_n;
        logic [47:0] want;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Model state: the run being collected and the verbatim setting.
    logic [7:0] run_store [RUN_DEPTH];
    int         run_len;
    logic       verbatim_mode;

    logic [7:0] burst_q [$];
    rendered_t  rendered_q [$];
    text_word_t word_plan_q [$];
    plan_row_t  plan_rows [$];

    int src_idle_pct;
    int dst_idle_pct;
    int words_sent;
    int results_checked;
    int runs_closed;
    int numeric_runs;
    int mismatches;

    html_text_entity_renderer #(
        .ENTITY_MAX_BYTES(RUN_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Rendering model
    // ------------------------------------------------------------------------

    // One step never emits more than MAX_RESULTS bytes; the rest is dropped.
    function automatic void put_out(input logic [7:0] b);
        if (burst_q.size() < MAX_RESULTS)
            burst_q.push_back(b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_out(s[i]);
    endfunction

    function automatic void put_escaped(input logic [7:0] b);
        case (b)
            CH_AMP:  put_text("&amp;");
            CH_LT:   put_text("&lt;");
            CH_GT:   put_text("&gt;");
            CH_QUOT: put_text("&quot;");
            default: put_out(b);
        endcase
    endfunction

    // U+FFFD is never escaped.
    function automatic void put_replacement();
        put_out(8'hEF);
        put_out(8'hBF);
        put_out(8'hBD);
    endfunction

    // Digit weight with byte wraparound for anything that is not a digit.
    function automatic logic [7:0] digit_of(input logic [7:0] c, input bit hex);
        logic [7:0] d;
        if (!hex || (c >= CH_ZERO && c <= CH_NINE))
            d = c - CH_ZERO;
        else if (c >= CH_UA && c <= CH_UZ)
            d = c - CH_UA + 8'd10;
        else
            d = c - CH_LA + 8'd10;
        return d;
    endfunction

    // UTF-8 encode a code point; zero and out-of-range values give U+FFFD.
    function automatic void put_code_point(input int unsigned cp);
        if (cp == 0 || cp > CP_LIMIT)
            put_replacement();
        else if (cp <= 32'h7F)
            put_escaped(cp[7:0]);
        else if (cp <= 32'h7FF)
        begin
            put_escaped({3'b110, cp[10:6]});
            put_escaped({2'b10, cp[5:0]});
        end
        else if (cp <= 32'hFFFF)
        begin
            put_escaped({4'b1110, cp[15:12]});
            put_escaped({2'b10, cp[11:6]});
            put_escaped({2'b10, cp[5:0]});
        end
        else
        begin
            put_escaped({5'b11110, cp[20:18]});
            put_escaped({2'b10, cp[17:12]});
            put_escaped({2'b10, cp[11:6]});
            put_escaped({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void render_run();
        int unsigned acc;
        int          stop;
        bit          hex;
        runs_closed++;
        if (verbatim_mode)
        begin
            for (int i = 0; i < run_len; i++)
                put_out(run_store[i]);
            return;
        end
        // Numeric reference: at least four bytes with '#' in second place.
        if (run_len > 3 && run_store[1] == CH_HASH)
        begin
            hex  = (run_store[2] == CH_LX || run_store[2] == CH_UX);
            stop = (run_store[run_len - 1] == CH_SEMI) ? run_len - 1 : run_len;
            acc  = 0;
            for (int i = hex ? 3 : 2; i < stop; i++)
            begin
                acc = acc * (hex ? 32'd16 : 32'd10) + digit_of(run_store[i], hex);
                if (acc > CP_LIMIT)
                    acc = CP_SAT;
            end
            numeric_runs++;
            put_code_point(acc);
            return;
        end
        for (int i = 0; i < run_len; i++)
            put_escaped(run_store[i]);
    endfunction

    // Work out the output bytes of one accepted word into burst_q.
    function automatic void render_word(input text_word_t w);
        burst_q.delete();
        case (w.kind)
            KIND_TEXT:   put_escaped(w.data);
            KIND_NULL:   put_replacement();
            KIND_ENTITY:
            begin
                // Bytes past the store depth are dropped.
                if (run_len < RUN_DEPTH)
                begin
                    run_store[run_len] = w.data;
                    run_len++;
                end
                if (w.last)
                begin
                    render_run();
                    run_len = 0;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------------
    function automatic void check_result(input logic [7:0] got_b, input logic got_l);
        rendered_t want;
        results_checked++;
        if (rendered_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected output word byte=%02h last=%0b",
                         $realtime, got_b, got_l);
            return;
        end
        want = rendered_q.pop_front();
        if (got_b !== want.b || got_l !== want.last)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: output mismatch byte exp %02h got %02h, last exp %0b got %0b",
                         $realtime, want.b, got_b, want.last, got_l);
        end
    endfunction

    // The receiver stalls at random and checks every word it takes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    function automatic void plan_word(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last);
        text_word_t w;
        w.kind = kind;
        w.data = data;
        w.last = last;
        word_plan_q.push_back(w);
    endfunction

    // A byte that leans toward the characters the renderer treats specially.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(11))
            0:       b = CH_AMP;
            1:       b = CH_LT;
            2:       b = CH_GT;
            3:       b = CH_QUOT;
            4:       b = CH_HASH;
            5:       b = CH_SEMI;
            6:       b = CH_LX;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // Numeric reference with random content; with split set, a text or null
    // word lands in the middle of the run.
    function automatic void plan_numeric_ref(input bit split);
        int unsigned cp;
        string       digits;
        string       body;
        bit          hex;
        int          cut;
        case ($urandom_range(7))
            0: cp = 0;
            1:
            begin
                case ($urandom_range(5))
                    0:       cp = CH_AMP;
                    1:       cp = CH_LT;
                    2:       cp = CH_GT;
                    3:       cp = CH_QUOT;
                    default: cp = $urandom_range(32'h7F, 1);
                endcase
            end
            2: cp = $urandom_range(32'h7FF, 32'h80);
            3: cp = $urandom_range(32'hFFFF, 32'h800);
            4: cp = $urandom_range(32'h10FFFF, 32'h10000);
            5: cp = 32'h10FFFF + $urandom_range(1);
            6: cp = $urandom();
            default: cp = $urandom_range(32'hDFFF, 32'hD800);
        endcase
        hex = 1'($urandom_range(1));
        if (hex)
        begin
            digits = $sformatf("%0h", cp);
            if ($urandom_range(1))
                digits = digits.toupper();
        end
        else
            digits = $sformatf("%0d", cp);
        if ($urandom_range(3) == 0)
            digits = {"00", digits};
        // Now and then a stray byte among the digits, or no digits at all.
        if ($urandom_range(9) == 0)
            digits[$urandom_range(digits.len() - 1)] = 8'($urandom_range(255, 1));
        if ($urandom_range(15) == 0)
            digits = "";
        body = "&#";
        if (hex)
            body = {body, ($urandom_range(1) ? "x" : "X")};
        body = {body, digits};
        if ($urandom_range(6) != 0)
            body = {body, ";"};
        cut = $urandom_range(body.len() - 1, 1);
        for (int i = 0; i < body.len(); i++)
        begin
            if (split && i == cut)
            begin
                if ($urandom_range(3) == 0)
                    plan_word(KIND_NULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
                else
                    plan_word(KIND_TEXT, pick_byte(), 1'($urandom_range(1)));
            end
            plan_word(KIND_ENTITY, body[i], i == body.len() - 1);
        end
    endfunction

    function automatic void plan_sequence();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 40)
            plan_numeric_ref(1'b0);
        else if (pick < 46)
            plan_numeric_ref(1'b1);
        else if (pick < 56)
        begin
            // Named-looking entity, re-emitted escaped outside verbatim mode.
            n = $urandom_range(8, 1);
            plan_word(KIND_ENTITY, CH_AMP, 1'b0);
            for (int i = 0; i < n; i++)
                plan_word(KIND_ENTITY, 8'(CH_LA + $urandom_range(25)), 1'b0);
            plan_word(KIND_ENTITY, CH_SEMI, 1'b1);
        end
        else if (pick < 64)
        begin
            // Short run of arbitrary bytes.
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                plan_word(KIND_ENTITY, (i == 1 && $urandom_range(1)) ? CH_HASH : pick_byte(),
                          i == n - 1);
        end
        else if (pick < 67)
        begin
            // Run longer than the store: a saturating number or a burst of
            // escapes that overruns the output limit.
            n = $urandom_range(RUN_DEPTH + 8, RUN_DEPTH + 1);
            if ($urandom_range(1))
            begin
                for (int i = 0; i < n; i++)
                    plan_word(KIND_ENTITY, (i == 0) ? CH_AMP : (i == 1) ? CH_HASH :
                              8'(CH_ZERO + $urandom_range(9)), i == n - 1);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    plan_word(KIND_ENTITY, pick_byte(), i == n - 1);
            end
        end
        else if (pick < 85)
        begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
                plan_word(KIND_TEXT, pick_byte(), 1'($urandom_range(1)));
        end
        else if (pick < 90)
            plan_word(KIND_NULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
        else if (pick < 93)
            plan_word(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
        else
        begin
            // Unterminated run; the next entity bytes extend it.
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
                plan_word(KIND_ENTITY, pick_byte(), 1'b0);
        end
    endfunction

    function automatic void add_row(input bit is_cfg, input logic [1:0] kind,
                                    input logic [7:0] data, input logic last,
                                    input int want_n, input logic [47:0] want);
        plan_row_t r;
        r.is_cfg = is_cfg;
        r.kind   = kind;
        r.data   = data;
        r.last   = last;
        r.want_n = want_n;
        r.want   = want;
        plan_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offer one word, wait for it to be taken, then queue its output bytes.
    task automatic send_word(input text_word_t w, input int want_n, input logic [47:0] want);
        logic [47:0] bytes;
        rendered_t   r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w.data;
        s_tuser  <= w.kind;
        s_tlast  <= w.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        render_word(w);
        if (want_n == USE_MODEL)
        begin
            foreach (burst_q[i])
            begin
                r.b    = burst_q[i];
                r.last = (i == burst_q.size() - 1);
                rendered_q.push_back(r);
            end
        end
        else
        begin
            bytes = want;
            for (int i = 0; i < want_n; i++)
            begin
                r.b    = bytes[47:40];
                r.last = (i == want_n - 1);
                rendered_q.push_back(r);
                bytes  = bytes << 8;
            end
        end
    endtask

    // Let everything drain, then write the verbatim register.
    task automatic set_verbatim(input logic v);
        s_tvalid <= 1'b0;
        while (rendered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        verbatim_mode = v;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        text_word_t w;
        int         phase_words;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        s_tuser         = KIND_TEXT;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        run_len         = 0;
        verbatim_mode   = 1'b0;
        src_idle_pct    = 38;
        dst_idle_pct    = 55;
        words_sent      = 0;
        results_checked = 0;
        runs_closed     = 0;
        numeric_runs    = 0;
        mismatches      = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: escapes, extremes, null, the unused kind, numeric
        // and hex references, an empty hex reference and verbatim mode.
        add_row(1'b1, KIND_TEXT, 8'h00, 1'b0, 0, '0);
        add_row(1'b0, KIND_TEXT, 8'h00, 1'b0, 1, {8'h00, 40'h0});
        add_row(1'b0, KIND_TEXT, 8'hFF, 1'b1, 1, {8'hFF, 40'h0});
        add_row(1'b0, KIND_TEXT, CH_AMP, 1'b0, 5, {"&amp;", 8'h00});
        add_row(1'b0, KIND_TEXT, CH_LT, 1'b0, 4, {"&lt;", 16'h0});
        add_row(1'b0, KIND_TEXT, CH_GT, 1'b1, 4, {"&gt;", 16'h0});
        add_row(1'b0, KIND_TEXT, CH_QUOT, 1'b0, 6, "&quot;");
        add_row(1'b0, KIND_NULL, 8'hA5, 1'b1, 3, {24'hEFBFBD, 24'h0});
        add_row(1'b0, KIND_UNUSED, 8'hFF, 1'b1, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_AMP, 1'b1, 5, {"&amp;", 8'h00});
        add_row(1'b0, KIND_ENTITY, CH_AMP, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_HASH, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, "6", 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, "5", 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_SEMI, 1'b1, 1, {"A", 40'h0});
        add_row(1'b0, KIND_ENTITY, CH_AMP, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_HASH, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_UX, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_SEMI, 1'b1, 3, {24'hEFBFBD, 24'h0});
        add_row(1'b0, KIND_ENTITY, CH_AMP, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_HASH, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_LX, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, "e", 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, "9", 1'b1, USE_MODEL, '0);
        add_row(1'b1, KIND_TEXT, 8'h01, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_AMP, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_HASH, 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, "6", 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, "5", 1'b0, 0, '0);
        add_row(1'b0, KIND_ENTITY, CH_SEMI, 1'b1, 5, {"&#65;", 8'h00});
        add_row(1'b0, KIND_TEXT, CH_AMP, 1'b1, 5, {"&amp;", 8'h00});

        foreach (plan_rows[i])
        begin
            if (plan_rows[i].is_cfg)
                set_verbatim(plan_rows[i].data[0]);
            else
            begin
                w.kind = plan_rows[i].kind;
                w.data = plan_rows[i].data;
                w.last = plan_rows[i].last;
                send_word(w, plan_rows[i].want_n, plan_rows[i].want);
            end
        end

        // Random phases: flow control swaps sides, then runs without stalls;
        // verbatim mode is on in the middle phase only.
        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct = (p == 0) ? 38 : (p == 1) ? 55 : 0;
            dst_idle_pct = (p == 0) ? 55 : (p == 1) ? 38 : 0;
            set_verbatim(p == 1);
            phase_words = 0;
            while (phase_words < RANDOM_PER_PHASE)
            begin
                plan_sequence();
                while (word_plan_q.size() != 0)
                begin
                    w = word_plan_q.pop_front();
                    send_word(w, USE_MODEL, '0);
                    if (w.kind != KIND_UNUSED)
                        phase_words++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (rendered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (rendered_q.size() != 0)
            mismatches += rendered_q.size();

        $display("Sent %0d words with %0d entity runs closed, %0d of them decoded as numbers.",
                 words_sent, runs_closed, numeric_runs);
        $display("Checked %0d output words across both verbatim settings; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("[html_text_entity_renderer] OK");
        else
            $display("[html_text_entity_renderer] ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_TIME);
        $display("Timed out with %0d output words still expected.", rendered_q.size());
        $display("[html_text_entity_renderer] ERROR");
        $finish;
    end

endmodule
